// File: src/char_lcd_nibble_sequencer_core_macros.svh
// Assertion helpers shared by the sequencer modules.
// Each expects clk and arst_n in scope.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define LCDNS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCDNS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lcdns_pkg.sv
package lcdns_pkg;

	typedef enum logic [3:0] {
		ACT_INIT    = 4'd0,
		ACT_CLEAR   = 4'd1,
		ACT_HOME    = 4'd2,
		ACT_CURSOR  = 4'd3,
		ACT_DATA    = 4'd4,
		ACT_COMMAND = 4'd5,
		ACT_CGRAM   = 4'd6,
		ACT_FLAG    = 4'd7,
		ACT_SCROLL  = 4'd8
	} action_t;

	typedef enum logic [2:0] {
		FLAG_DISPLAY    = 3'd0,
		FLAG_CURSOR     = 3'd1,
		FLAG_BLINK      = 3'd2,
		FLAG_LEFT_RIGHT = 3'd3,
		FLAG_AUTOSCROLL = 3'd4
	} flag_id_t;

	localparam logic [7:0] CMD_CLEAR       = 8'h01;
	localparam logic [7:0] CMD_HOME        = 8'h02;
	localparam logic [7:0] CMD_ENTRY_MODE  = 8'h04;
	localparam logic [7:0] CMD_DISP_CTRL   = 8'h08;
	localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
	localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
	localparam logic [7:0] CMD_SET_CGRAM   = 8'h40;
	localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;

	localparam logic [2:0] DISP_CTRL_INIT  = 3'b100;
	localparam logic [1:0] ENTRY_MODE_INIT = 2'b10;

	localparam int WAIT_W = 13;
	localparam int LEAD_W = 16;
	localparam logic [WAIT_W-1:0] SETTLE_US     = 13'd100;
	localparam logic [WAIT_W-1:0] WAKE_LONG_US  = 13'd4500;
	localparam logic [WAIT_W-1:0] WAKE_SHORT_US = 13'd150;
	localparam logic [WAIT_W-1:0] SLOW_CMD_US   = 13'd2000;
	localparam logic [LEAD_W-1:0] POWERUP_US    = 16'd50000;

	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] INIT_LAST_IDX = 4'd11;
	localparam logic [IDX_W-1:0] INIT_CLEAR_LO = 4'd9;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic       init;
		logic       rs;
		logic [7:0] code;
		logic       slow;
	} entry_t;

	// nibble sequence of the power-up routine
	function automatic logic [3:0] init_nibble(input logic [IDX_W-1:0] idx);
		logic [3:0] n;
		case (idx)
			4'd0, 4'd1, 4'd2: n = 4'h3;
			4'd3, 4'd4:       n = 4'h2;
			4'd5:             n = 4'h8;
			4'd6, 4'd8, 4'd10: n = 4'h0;
			4'd7:             n = 4'hC;
			4'd9:             n = 4'h1;
			4'd11:            n = 4'h6;
			default:          n = 4'h0;
		endcase
		return n;
	endfunction

	function automatic logic [WAIT_W-1:0] init_wait(input logic [IDX_W-1:0] idx);
		logic [WAIT_W-1:0] w;
		case (idx)
			4'd0, 4'd1:    w = SETTLE_US + WAKE_LONG_US;
			4'd2:          w = SETTLE_US + WAKE_SHORT_US;
			INIT_CLEAR_LO: w = SETTLE_US + SLOW_CMD_US;
			default:       w = SETTLE_US;
		endcase
		return w;
	endfunction

endpackage

// File: src/lcdns_if.sv
interface lcdns_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [7:0] data_byte;
	logic [5:0] col;
	logic [1:0] row;
	logic [2:0] slot;
	logic [2:0] flag_id;
	logic       flag_value;
	logic       direction;

	modport source (
		output valid, action, data_byte, col, row, slot, flag_id, flag_value, direction,
		input  ready
	);
	modport sink (
		input  valid, action, data_byte, col, row, slot, flag_id, flag_value, direction,
		output ready
	);
endinterface

interface lcdns_res_if;
	logic        valid;
	logic        ready;
	logic        rs;
	logic [3:0]  nibble;
	logic [15:0] lead_wait_us;
	logic [12:0] wait_after_us;
	logic        last;

	modport source (
		output valid, rs, nibble, lead_wait_us, wait_after_us, last,
		input  ready
	);
	modport sink (
		input  valid, rs, nibble, lead_wait_us, wait_after_us, last,
		output ready
	);
endinterface

// File: src/char_lcd_nibble_sequencer_core.sv
// Character display sequencer for a 4-bit parallel bus.
// req channel: one request per transfer (action plus its operands). Unknown
// actions and unknown flag ids are taken and produce nothing.
// res channel: one transfer per enable pulse: rs, nibble D7..D4, the power-up
// wait before the pulse, the idle time after it, and last on the final
// nibble of the request. Bytes go out high nibble first.
// The first nibble of a request goes through the queue and the output
// register before it is offered. Throughput: one nibble per cycle from the
// single output register while res.ready is high; byte requests give two
// nibbles, init twelve; a small queue takes requests while older ones go out.
// Display-control and entry-mode shadow bits are updated as requests are
// taken and persist between requests.
// Reset clears the shadows to zero, empties the queue and drops any pending
// nibble. When the receiver holds ready low the current nibble stays put,
// the queue fills and then req.ready drops.
module char_lcd_nibble_sequencer_core #(
	parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	lcdns_req_if.sink   req,
	lcdns_res_if.source res
);

	logic              fq_valid;
	logic              fq_ready;
	lcdns_pkg::entry_t fq_data;
	logic              bq_valid;
	logic              bq_pop;
	lcdns_pkg::entry_t bq_data;

	lcdns_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_data  (fq_data)
	);

	lcdns_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (bq_valid),
		.out_ready (bq_pop),
		.out_data  (bq_data)
	);

	lcdns_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (bq_valid),
		.q_pop   (bq_pop),
		.q_data  (bq_data),
		.res     (res)
	);

endmodule

// File: src/lcdns_front.sv
module lcdns_front (
	input  logic                clk,
	input  logic                arst_n,
	lcdns_req_if.sink           req,
	output logic                q_valid,
	input  logic                q_ready,
	output lcdns_pkg::entry_t   q_data
);

	logic [2:0] disp_q;
	logic [1:0] entry_q;
	logic [2:0] disp_d;
	logic [1:0] entry_d;
	logic       known;
	logic       push;

	always_comb begin
		q_data  = '0;
		known   = 1'b1;
		disp_d  = disp_q;
		entry_d = entry_q;
		case (req.action)
			lcdns_pkg::ACT_INIT: begin
				q_data.init = 1'b1;
				disp_d      = lcdns_pkg::DISP_CTRL_INIT;
				entry_d     = lcdns_pkg::ENTRY_MODE_INIT;
			end
			lcdns_pkg::ACT_CLEAR: begin
				q_data.code = lcdns_pkg::CMD_CLEAR;
				q_data.slow = 1'b1;
			end
			lcdns_pkg::ACT_HOME: begin
				q_data.code = lcdns_pkg::CMD_HOME;
				q_data.slow = 1'b1;
			end
			lcdns_pkg::ACT_CURSOR: begin
				// rows 1..3 all land on the second line
				q_data.code = lcdns_pkg::CMD_SET_DDRAM | {1'b0, (req.row != 2'd0), req.col};
			end
			lcdns_pkg::ACT_DATA: begin
				q_data.rs   = 1'b1;
				q_data.code = req.data_byte;
			end
			lcdns_pkg::ACT_COMMAND: begin
				q_data.code = req.data_byte;
			end
			lcdns_pkg::ACT_CGRAM: begin
				q_data.code = lcdns_pkg::CMD_SET_CGRAM | {2'b00, req.slot, 3'b000};
			end
			lcdns_pkg::ACT_FLAG: begin
				case (req.flag_id)
					lcdns_pkg::FLAG_DISPLAY:    disp_d[2]  = req.flag_value;
					lcdns_pkg::FLAG_CURSOR:     disp_d[1]  = req.flag_value;
					lcdns_pkg::FLAG_BLINK:      disp_d[0]  = req.flag_value;
					lcdns_pkg::FLAG_LEFT_RIGHT: entry_d[1] = req.flag_value;
					lcdns_pkg::FLAG_AUTOSCROLL: entry_d[0] = req.flag_value;
					default:                    known      = 1'b0;
				endcase
				if (req.flag_id inside {lcdns_pkg::FLAG_DISPLAY, lcdns_pkg::FLAG_CURSOR,
						lcdns_pkg::FLAG_BLINK}) begin
					q_data.code = lcdns_pkg::CMD_DISP_CTRL | {5'b00000, disp_d};
				end else begin
					q_data.code = lcdns_pkg::CMD_ENTRY_MODE | {6'b000000, entry_d};
				end
			end
			lcdns_pkg::ACT_SCROLL: begin
				q_data.code = req.direction ? lcdns_pkg::CMD_SHIFT_RIGHT
				                            : lcdns_pkg::CMD_SHIFT_LEFT;
			end
			default: known = 1'b0;
		endcase
	end

	// unknown requests are taken and dropped
	assign req.ready = q_ready;
	assign q_valid   = req.valid && known;
	assign push      = req.valid && q_ready && known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q  <= '0;
			entry_q <= '0;
		end else if (push) begin
			disp_q  <= disp_d;
			entry_q <= entry_d;
		end
	end

endmodule

// File: src/lcdns_fifo.sv
`include "char_lcd_nibble_sequencer_core_macros.svh"

module lcdns_fifo #(
	parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lcdns_pkg::entry_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output lcdns_pkg::entry_t out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lcdns_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`LCDNS_ASSERT_NEXT(a_push_shows, push && !pop, out_valid, "queue empty after a push")
	`LCDNS_ASSERT_NEXT(a_drain_empties, pop && !push && count_q == CW'(1), !out_valid, "queue not empty after draining its only entry")
	`LCDNS_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(DEPTH), "queue count past its depth")

endmodule

// File: src/lcdns_back.sv
`include "char_lcd_nibble_sequencer_core_macros.svh"

module lcdns_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  lcdns_pkg::entry_t q_data,
	lcdns_res_if.source       res
);

	logic [lcdns_pkg::IDX_W-1:0]  idx_q;
	logic                         out_valid_q;
	logic                         rs_q;
	logic [3:0]                   nib_q;
	logic [lcdns_pkg::LEAD_W-1:0] lead_q;
	logic [lcdns_pkg::WAIT_W-1:0] after_q;
	logic                         last_q;

	logic                         ld;
	logic                         is_last;
	logic [3:0]                   nib_d;
	logic [lcdns_pkg::LEAD_W-1:0] lead_d;
	logic [lcdns_pkg::WAIT_W-1:0] after_d;

	always_comb begin
		if (q_data.init) begin
			nib_d   = lcdns_pkg::init_nibble(idx_q);
			after_d = lcdns_pkg::init_wait(idx_q);
			lead_d  = (idx_q == '0) ? lcdns_pkg::POWERUP_US : '0;
			is_last = (idx_q == lcdns_pkg::INIT_LAST_IDX);
		end else begin
			// high nibble first, slow commands wait after the low one
			nib_d   = idx_q[0] ? q_data.code[3:0] : q_data.code[7:4];
			after_d = (idx_q[0] && q_data.slow)
			          ? lcdns_pkg::SETTLE_US + lcdns_pkg::SLOW_CMD_US
			          : lcdns_pkg::SETTLE_US;
			lead_d  = '0;
			is_last = idx_q[0];
		end
	end

	assign ld    = q_valid && (!out_valid_q || res.ready);
	assign q_pop = ld && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rs_q    <= q_data.rs;
			nib_q   <= nib_d;
			lead_q  <= lead_d;
			after_q <= after_d;
			last_q  <= is_last;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.rs            = rs_q;
	assign res.nibble        = nib_q;
	assign res.lead_wait_us  = lead_q;
	assign res.wait_after_us = after_q;
	assign res.last          = last_q;

	`LCDNS_ASSERT_NOW(a_byte_idx, q_valid && !q_data.init, idx_q <= lcdns_pkg::IDX_W'(1), "byte entry index past its low nibble")
	`LCDNS_ASSERT_NEXT(a_entry_held, ld && !is_last, q_valid, "entry left the queue before its last nibble")
	`LCDNS_ASSERT_NOW(a_lead_first, ld && lead_d != '0, idx_q == '0, "power-up wait on a later nibble")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
	localparam logic [3:0] BUS_4BIT_NIBBLE  = 4'h2;
	localparam logic [7:0] FUNC_SET_2LINE   = 8'h28;
	localparam logic [7:0] DDRAM_ROW_STRIDE = 8'h40;
	localparam logic [3:0] ACT_UNKNOWN_LO   = 4'd9;
	localparam logic [3:0] ACT_UNKNOWN_HI   = 4'd15;
	localparam logic [2:0] FLAG_UNKNOWN_LO  = 3'd5;
	localparam logic [2:0] FLAG_UNKNOWN_HI  = 3'd7;
	localparam int         TAIL_CYCLES      = 20;

	typedef struct {
		logic [3:0] action;
		logic [7:0] data_byte;
		logic [5:0] col;
		logic [1:0] row;
		logic [2:0] slot;
		logic [2:0] flag_id;
		logic       flag_value;
		logic       direction;
	} lcd_request_t;

	typedef struct {
		logic        rs;
		logic [3:0]  nibble;
		logic [15:0] lead_wait_us;
		logic [12:0] wait_after_us;
		logic        last;
	} nibble_xfer_t;

	logic clk;
	logic arst_n;

	lcdns_req_if req_bus();
	lcdns_res_if res_bus();

	char_lcd_nibble_sequencer_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.res    (res_bus)
	);

	// shadow copies of the display-control and entry-mode bits
	logic [2:0] shadow_disp_ctrl;
	logic [1:0] shadow_entry_mode;

	nibble_xfer_t pending_nibbles[$];
	int           error_count;
	int           src_idle_pct;
	int           sink_stall_pct;
	int           hold_off_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	// receiver: random stalls, or a counted hold-off stretch
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			res_bus.ready <= 1'b0;
			hold_off_left <= hold_off_left - 1;
		end else begin
			res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		nibble_xfer_t exp_x;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_nibbles.size() == 0) begin
				$error("unexpected transfer: rs %0d nibble %0h", res_bus.rs, res_bus.nibble);
				error_count++;
			end else begin
				exp_x = pending_nibbles.pop_front();
				if (res_bus.rs !== exp_x.rs) begin
					$error("rs expected %0d got %0d", exp_x.rs, res_bus.rs);
					error_count++;
				end
				if (res_bus.nibble !== exp_x.nibble) begin
					$error("nibble expected %0h got %0h", exp_x.nibble, res_bus.nibble);
					error_count++;
				end
				if (res_bus.lead_wait_us !== exp_x.lead_wait_us) begin
					$error("lead_wait_us expected %0d got %0d",
						exp_x.lead_wait_us, res_bus.lead_wait_us);
					error_count++;
				end
				if (res_bus.wait_after_us !== exp_x.wait_after_us) begin
					$error("wait_after_us expected %0d got %0d",
						exp_x.wait_after_us, res_bus.wait_after_us);
					error_count++;
				end
				if (res_bus.last !== exp_x.last) begin
					$error("last expected %0d got %0d", exp_x.last, res_bus.last);
					error_count++;
				end
			end
		end
	end

	function automatic void push_nibble(logic rs, logic [3:0] nib, logic [15:0] lead,
			logic [12:0] wait_us, logic is_last);
		nibble_xfer_t x;
		x.rs            = rs;
		x.nibble        = nib;
		x.lead_wait_us  = lead;
		x.wait_after_us = wait_us;
		x.last          = is_last;
		pending_nibbles.push_back(x);
	endfunction

	// high nibble first; any extra delay goes after the low nibble
	function automatic void push_byte(logic rs, logic [7:0] code, logic [12:0] extra_us,
			logic is_last);
		push_nibble(rs, code[7:4], '0, lcdns_pkg::SETTLE_US, 1'b0);
		push_nibble(rs, code[3:0], '0, lcdns_pkg::SETTLE_US + extra_us, is_last);
	endfunction

	// expected nibbles for one request; returns how many it causes
	function automatic int predict_nibbles(lcd_request_t r);
		int         n_before;
		logic [1:0] eff_row;
		logic [7:0] addr;
		logic [2:0] disp_mask;
		n_before = pending_nibbles.size();
		case (r.action)
			lcdns_pkg::ACT_INIT: begin
				push_nibble(1'b0, WAKE_NIBBLE, lcdns_pkg::POWERUP_US,
					lcdns_pkg::SETTLE_US + lcdns_pkg::WAKE_LONG_US, 1'b0);
				push_nibble(1'b0, WAKE_NIBBLE, '0,
					lcdns_pkg::SETTLE_US + lcdns_pkg::WAKE_LONG_US, 1'b0);
				push_nibble(1'b0, WAKE_NIBBLE, '0,
					lcdns_pkg::SETTLE_US + lcdns_pkg::WAKE_SHORT_US, 1'b0);
				push_nibble(1'b0, BUS_4BIT_NIBBLE, '0, lcdns_pkg::SETTLE_US, 1'b0);
				push_byte(1'b0, FUNC_SET_2LINE, '0, 1'b0);
				shadow_disp_ctrl = lcdns_pkg::DISP_CTRL_INIT;
				push_byte(1'b0, lcdns_pkg::CMD_DISP_CTRL | {5'b0, shadow_disp_ctrl}, '0, 1'b0);
				push_byte(1'b0, lcdns_pkg::CMD_CLEAR, lcdns_pkg::SLOW_CMD_US, 1'b0);
				shadow_entry_mode = lcdns_pkg::ENTRY_MODE_INIT;
				push_byte(1'b0, lcdns_pkg::CMD_ENTRY_MODE | {6'b0, shadow_entry_mode}, '0,
					1'b1);
			end
			lcdns_pkg::ACT_CLEAR:
				push_byte(1'b0, lcdns_pkg::CMD_CLEAR, lcdns_pkg::SLOW_CMD_US, 1'b1);
			lcdns_pkg::ACT_HOME:
				push_byte(1'b0, lcdns_pkg::CMD_HOME, lcdns_pkg::SLOW_CMD_US, 1'b1);
			lcdns_pkg::ACT_CURSOR: begin
				eff_row = (r.row >= 2) ? 2'd1 : r.row;
				addr = {2'b0, r.col} + (eff_row[0] ? DDRAM_ROW_STRIDE : 8'h00);
				push_byte(1'b0, lcdns_pkg::CMD_SET_DDRAM | addr, '0, 1'b1);
			end
			lcdns_pkg::ACT_DATA:    push_byte(1'b1, r.data_byte, '0, 1'b1);
			lcdns_pkg::ACT_COMMAND: push_byte(1'b0, r.data_byte, '0, 1'b1);
			lcdns_pkg::ACT_CGRAM:
				push_byte(1'b0, lcdns_pkg::CMD_SET_CGRAM | {2'b0, r.slot, 3'b0}, '0, 1'b1);
			lcdns_pkg::ACT_FLAG: begin
				case (r.flag_id)
					lcdns_pkg::FLAG_DISPLAY, lcdns_pkg::FLAG_CURSOR,
					lcdns_pkg::FLAG_BLINK: begin
						disp_mask = 3'b100 >> r.flag_id;
						shadow_disp_ctrl = r.flag_value ? (shadow_disp_ctrl | disp_mask)
							: (shadow_disp_ctrl & ~disp_mask);
						push_byte(1'b0, lcdns_pkg::CMD_DISP_CTRL | {5'b0, shadow_disp_ctrl},
							'0, 1'b1);
					end
					lcdns_pkg::FLAG_LEFT_RIGHT: begin
						shadow_entry_mode[1] = r.flag_value;
						push_byte(1'b0, lcdns_pkg::CMD_ENTRY_MODE | {6'b0, shadow_entry_mode},
							'0, 1'b1);
					end
					lcdns_pkg::FLAG_AUTOSCROLL: begin
						shadow_entry_mode[0] = r.flag_value;
						push_byte(1'b0, lcdns_pkg::CMD_ENTRY_MODE | {6'b0, shadow_entry_mode},
							'0, 1'b1);
					end
					default: ;
				endcase
			end
			lcdns_pkg::ACT_SCROLL:
				push_byte(1'b0, r.direction ? lcdns_pkg::CMD_SHIFT_RIGHT
					: lcdns_pkg::CMD_SHIFT_LEFT, '0, 1'b1);
			default: ;
		endcase
		return pending_nibbles.size() - n_before;
	endfunction

	// the caller supplies unused operands too, random or varied, so every input bit toggles
	function automatic lcd_request_t make_request(logic [3:0] action, logic [7:0] data_byte,
			logic [5:0] col, logic [1:0] row, logic [2:0] slot, logic [2:0] flag_id,
			logic flag_value, logic direction);
		lcd_request_t r;
		r.action     = action;
		r.data_byte  = data_byte;
		r.col        = col;
		r.row        = row;
		r.slot       = slot;
		r.flag_id    = flag_id;
		r.flag_value = flag_value;
		r.direction  = direction;
		return r;
	endfunction

	function automatic lcd_request_t random_request();
		int           pick;
		lcd_request_t r;
		pick = $urandom_range(99);
		r = make_request('0, 8'($urandom_range(255)), 6'($urandom_range(63)),
			2'($urandom_range(3)), 3'($urandom_range(7)), '0, 1'($urandom_range(1)),
			1'($urandom_range(1)));
		if (pick < 4)
			r.action = lcdns_pkg::ACT_INIT;
		else if (pick < 9)
			r.action = 4'($urandom_range(ACT_UNKNOWN_HI, ACT_UNKNOWN_LO));
		else
			r.action = 4'($urandom_range(lcdns_pkg::ACT_SCROLL, lcdns_pkg::ACT_CLEAR));
		r.flag_id = ($urandom_range(99) < 85)
			? 3'($urandom_range(lcdns_pkg::FLAG_AUTOSCROLL, lcdns_pkg::FLAG_DISPLAY))
			: 3'($urandom_range(FLAG_UNKNOWN_HI, FLAG_UNKNOWN_LO));
		return r;
	endfunction

	task automatic send_request(input lcd_request_t r, output int n_nibbles);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.action     <= r.action;
		req_bus.data_byte  <= r.data_byte;
		req_bus.col        <= r.col;
		req_bus.row        <= r.row;
		req_bus.slot       <= r.slot;
		req_bus.flag_id    <= r.flag_id;
		req_bus.flag_value <= r.flag_value;
		req_bus.direction  <= r.direction;
		do @(posedge clk); while (!req_bus.ready);
		n_nibbles = predict_nibbles(r);
	endtask

	// sender pauses until every expected transfer has come back
	task automatic wait_drain();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (pending_nibbles.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		lcd_request_t reqs[$];
		int           n;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		// flag change from reset shadows, before any init
		reqs.push_back(make_request(lcdns_pkg::ACT_FLAG, 8'h5A, 6'd0, 2'd0, 3'd0,
			lcdns_pkg::FLAG_CURSOR, 1'b1, 1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_INIT, 8'hA5, 6'd63, 2'd3, 3'd7, 3'd7, 1'b1,
			1'b1));
		reqs.push_back(make_request(lcdns_pkg::ACT_CLEAR, 8'h00, 6'd21, 2'd1, 3'd2, 3'd1, 1'b0,
			1'b1));
		reqs.push_back(make_request(lcdns_pkg::ACT_HOME, 8'hFF, 6'd42, 2'd2, 3'd5, 3'd6, 1'b1,
			1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_CURSOR, 8'h00, 6'd0, 2'd0, 3'd0, 3'd0, 1'b0,
			1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_CURSOR, 8'hFF, 6'd63, 2'd3, 3'd7, 3'd7,
			1'b1, 1'b1));
		reqs.push_back(make_request(lcdns_pkg::ACT_CURSOR, 8'h33, 6'd5, 2'd2, 3'd1, 3'd2, 1'b0,
			1'b1));
		reqs.push_back(make_request(lcdns_pkg::ACT_CURSOR, 8'hCC, 6'd63, 2'd1, 3'd4, 3'd4,
			1'b1, 1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_DATA, 8'h00, 6'd0, 2'd0, 3'd0, 3'd0, 1'b0,
			1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_DATA, 8'hFF, 6'd63, 2'd3, 3'd7, 3'd7, 1'b1,
			1'b1));
		// raw clear and home codes take no extra delay
		reqs.push_back(make_request(lcdns_pkg::ACT_COMMAND, lcdns_pkg::CMD_CLEAR, 6'd9, 2'd0,
			3'd3, 3'd1, 1'b0, 1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_COMMAND, lcdns_pkg::CMD_HOME, 6'd17, 2'd1,
			3'd6, 3'd5, 1'b1, 1'b1));
		reqs.push_back(make_request(lcdns_pkg::ACT_CGRAM, 8'h11, 6'd3, 2'd2, 3'd0, 3'd3, 1'b1,
			1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_CGRAM, 8'hEE, 6'd60, 2'd1, 3'd7, 3'd4, 1'b0,
			1'b1));
		reqs.push_back(make_request(lcdns_pkg::ACT_FLAG, 8'h01, 6'd1, 2'd0, 3'd1,
			lcdns_pkg::FLAG_DISPLAY, 1'b0, 1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_FLAG, 8'h02, 6'd2, 2'd1, 3'd2,
			lcdns_pkg::FLAG_CURSOR, 1'b1, 1'b1));
		reqs.push_back(make_request(lcdns_pkg::ACT_FLAG, 8'h04, 6'd4, 2'd2, 3'd4,
			lcdns_pkg::FLAG_BLINK, 1'b1, 1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_FLAG, 8'h08, 6'd8, 2'd3, 3'd5,
			lcdns_pkg::FLAG_LEFT_RIGHT, 1'b0, 1'b1));
		reqs.push_back(make_request(lcdns_pkg::ACT_FLAG, 8'h10, 6'd16, 2'd0, 3'd6,
			lcdns_pkg::FLAG_AUTOSCROLL, 1'b1, 1'b0));
		// unknown flag ids change nothing
		reqs.push_back(make_request(lcdns_pkg::ACT_FLAG, 8'h20, 6'd32, 2'd1, 3'd7,
			FLAG_UNKNOWN_HI, 1'b1, 1'b1));
		reqs.push_back(make_request(lcdns_pkg::ACT_FLAG, 8'h40, 6'd48, 2'd2, 3'd3,
			FLAG_UNKNOWN_LO, 1'b0, 1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_SCROLL, 8'h80, 6'd7, 2'd3, 3'd2, 3'd2, 1'b0,
			1'b0));
		reqs.push_back(make_request(lcdns_pkg::ACT_SCROLL, 8'h7F, 6'd56, 2'd0, 3'd5, 3'd1,
			1'b1, 1'b1));
		// unknown actions are taken and dropped
		reqs.push_back(make_request(ACT_UNKNOWN_LO, 8'hC3, 6'd12, 2'd1, 3'd1, 3'd0, 1'b1, 1'b1));
		reqs.push_back(make_request(ACT_UNKNOWN_HI, 8'h3C, 6'd51, 2'd2, 3'd6, 3'd4, 1'b0, 1'b0));
		foreach (reqs[i])
			send_request(reqs[i], n);
		wait_drain();
	endtask

	task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
		int           taken;
		int           n;
		lcd_request_t r;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		taken = 0;
		while (taken < n_items) begin
			r = random_request();
			send_request(r, n);
			if (n > 0)
				taken++;
		end
		wait_drain();
	endtask

	// long receiver hold-off while requests keep coming; input must back up
	task automatic test_hold_off();
		int n;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_off_left  = 300;
		for (int i = 0; i < 30; i++)
			send_request(random_request(), n);
		wait_drain();
	endtask

	initial begin
		error_count        = 0;
		src_idle_pct       = 0;
		sink_stall_pct     = 0;
		hold_off_left      = 0;
		shadow_disp_ctrl   = '0;
		shadow_entry_mode  = '0;
		arst_n             = 1'b0;
		req_bus.valid      = 1'b0;
		req_bus.action     = '0;
		req_bus.data_byte  = '0;
		req_bus.col        = '0;
		req_bus.row        = '0;
		req_bus.slot       = '0;
		req_bus.flag_id    = '0;
		req_bus.flag_value = 1'b0;
		req_bus.direction  = 1'b0;
		res_bus.ready      = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(60, 0, 0);
		test_random(60, 84, 0);
		test_random(60, 0, 84);
		test_random(60, 37, 37);
		test_hold_off();
		test_random(40, 0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_nibbles.size() != 0) begin
			$error("%0d expected transfers never arrived", pending_nibbles.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/lcdns_pkg.sv
src/lcdns_if.sv
src/lcdns_front.sv
src/lcdns_fifo.sv
src/lcdns_back.sv
src/char_lcd_nibble_sequencer_core.sv
sim/testbench.sv
